[design/bsp_pkg.sv]
package bsp_pkg;

    localparam int MAX_ORDER_DEF  = 8;
    localparam int MAX_POINTS_DEF = 256;
    localparam int MAX_COORDS_DEF = 3;

    localparam int Q_FRAC = 16;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef enum logic [1:0] {
        CMD_KNOT = 2'd0,
        CMD_CTRL = 2'd1,
        CMD_EVAL = 2'd2
    } cmd_t;

    localparam logic [2:0] CFG_ORDER    = 3'd0;
    localparam logic [2:0] CFG_POINTS   = 3'd1;
    localparam logic [2:0] CFG_PERIODIC = 3'd2;
    localparam logic [2:0] CFG_RATIONAL = 3'd3;
    localparam logic [2:0] CFG_COORDS   = 3'd4;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7fff_ffff) begin
            r = 32'sh7fff_ffff;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // drop the fraction bits of a product, rounding toward zero
    function automatic logic signed [47:0] qtrunc(input logic signed [63:0] p);
        logic signed [63:0] adj;
        if (p < 0) begin
            adj = p + 64'sd65535;
        end else begin
            adj = p;
        end
        return adj[63:Q_FRAC];
    endfunction

endpackage

[design/bspline_curve_point_eval.sv]
// B-spline curve point evaluator, Cox-de Boor recursion, signed Q16.16.
// Input stream: s_tuser carries the command, s_tdata the operands. Knot and
// control-coordinate write items give no result; an evaluate item gives one
// result item on the m_ stream.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, as the block does not enforce it.
// Each recursion step runs up to two divides in the one-bit-per-cycle divider
// and up to two products in the shared multiplier.
// Only one item is in work at a time; s_tready is low from an evaluate item
// until its result has been taken.
// Reset (synchronous, aresetn low) clears the control state and sets the
// registers to order 4, four points, open, non-rational, three coordinates.
// Knot and control stores hold no reset value and must be written first.
// A stalled receiver holds the result in the output register; no input item
// is taken while it waits.
module bspline_curve_point_eval
    import bsp_pkg::*;
#(
    parameter int MAX_ORDER  = MAX_ORDER_DEF,
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_COORDS = MAX_COORDS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // slot, coord_sel, write_value, param_t, zero pad
    input  logic [1:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // out_w, out_x, out_y, out_z, first_index
    output logic         m_tuser,   // domain_error
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [8:0]   cfg_data
);

    localparam int KNOT_DEPTH = MAX_POINTS + 2 * MAX_ORDER;
    localparam int CTRL_DEPTH = (MAX_COORDS + 1) * MAX_POINTS;
    localparam int KAW = $clog2(KNOT_DEPTH);
    localparam int CAW = $clog2(CTRL_DEPTH);
    localparam int BW  = $clog2(MAX_ORDER + 1);
    localparam int IW_RAW = $clog2(KNOT_DEPTH + 2 * MAX_ORDER) + 1;
    localparam int IW  = (IW_RAW > 10) ? IW_RAW : 10;

    typedef enum logic [4:0] {
        S_IDLE, S_DOM0, S_DOM1, S_DOM2, S_SRCH0, S_SRCH1, S_BSET,
        S_CDB0, S_CDB1, S_CDB2, S_CDB3, S_CDB4, S_DIV, S_MUL, S_MULR, S_WB,
        S_SUM0, S_SUM1, S_SUM2, S_SUMM, S_SUM3, S_OUT
    } state_t;

    state_t state_reg;

    logic [3:0] cfg_order_reg;
    logic [8:0] cfg_points_reg;
    logic       cfg_periodic_reg;
    logic       cfg_rational_reg;
    logic [1:0] cfg_coords_reg;

    logic [1:0]         in_cmd;
    logic [8:0]         in_slot;
    logic [1:0]         in_csel;
    logic signed [31:0] in_value;
    logic signed [31:0] in_t;

    assign in_cmd   = s_tuser;
    assign in_slot  = s_tdata[8:0];
    assign in_csel  = s_tdata[10:9];
    assign in_value = s_tdata[42:11];
    assign in_t     = s_tdata[74:43];

    logic signed [31:0] knot_mem [KNOT_DEPTH];
    logic signed [31:0] ctrl_mem [CTRL_DEPTH];
    logic signed [31:0] basis_reg [MAX_ORDER + 1];

    logic signed [31:0] t_reg;
    logic [IW-1:0] n_reg, k_reg, len_reg, kvlen_reg, idx_reg, first_reg, i_reg, l_reg;
    logic          periodic_reg, rational_reg;
    logic [1:0]    nc_reg, c_reg;
    logic signed [31:0] lo_reg, hi_reg;
    logic signed [32:0] s1_reg, s2_reg;
    logic          term_b_reg;
    logic signed [47:0] a_reg, b_reg;
    logic signed [31:0] mul_a_reg, mul_b_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] res_reg [4];
    logic [7:0]    first_out_reg;
    logic          err_reg;
    logic          m_tvalid_reg;

    logic          accept;
    logic [IW-1:0] kaddr;
    logic          koob_reg;
    logic signed [31:0] krd_reg;
    logic signed [31:0] knot_val;
    logic [IW-1:0] p_raw, p_idx;
    logic          coob_reg;
    logic signed [31:0] crd_reg;
    logic signed [31:0] ctrl_val;
    logic [IW-1:0] bidx;
    logic signed [31:0] basis_rd;
    logic signed [32:0] s1_now;
    logic signed [47:0] qt;
    logic signed [63:0] acc_new;

    logic               div_start;
    logic signed [32:0] div_num;
    logic        [32:0] div_den;
    logic               div_done;
    logic signed [31:0] div_ratio;

    logic [IW-1:0] pc_ext, ko_ext, n_eff, k_tmp, k_eff, len_eff;
    logic [1:0]    nc_eff;

    assign s_tready = (state_reg == S_IDLE) && !m_tvalid_reg;
    assign accept   = s_tvalid && s_tready;

    // effective sizes
    always_comb begin
        pc_ext = IW'(cfg_points_reg);
        ko_ext = IW'(cfg_order_reg);
        if (pc_ext < IW'(2)) begin
            n_eff = IW'(2);
        end else if (pc_ext > IW'(MAX_POINTS)) begin
            n_eff = IW'(MAX_POINTS);
        end else begin
            n_eff = pc_ext;
        end
        if (ko_ext < IW'(2)) begin
            k_tmp = IW'(2);
        end else if (ko_ext > IW'(MAX_ORDER)) begin
            k_tmp = IW'(MAX_ORDER);
        end else begin
            k_tmp = ko_ext;
        end
        k_eff   = (k_tmp > n_eff) ? n_eff : k_tmp;
        len_eff = cfg_periodic_reg ? n_eff + k_eff - IW'(1) : n_eff;
        if (cfg_coords_reg == 2'd0) begin
            nc_eff = 2'd1;
        end else if (cfg_coords_reg > 2'(MAX_COORDS)) begin
            nc_eff = 2'(MAX_COORDS);
        end else begin
            nc_eff = cfg_coords_reg;
        end
    end

    // knot read address
    always_comb begin
        case (state_reg)
            S_DOM0:  kaddr = k_reg - IW'(1);
            S_DOM1:  kaddr = len_reg;
            S_SRCH0: kaddr = idx_reg + IW'(1);
            S_CDB0:  kaddr = idx_reg + l_reg + IW'(1);
            S_CDB1:  kaddr = idx_reg + l_reg - i_reg + IW'(2);
            S_CDB2:  kaddr = idx_reg + l_reg - i_reg + IW'(1);
            S_CDB3:  kaddr = idx_reg + l_reg;
            default: kaddr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept && in_cmd == CMD_KNOT && IW'(in_slot) < IW'(KNOT_DEPTH)) begin
            knot_mem[in_slot[KAW-1:0]] <= in_value;
        end
        krd_reg  <= knot_mem[kaddr[KAW-1:0]];
        koob_reg <= kaddr >= IW'(KNOT_DEPTH);
    end

    assign knot_val = koob_reg ? 32'sd0 : krd_reg;

    // control read address, wrapped for periodic curves
    assign p_raw = first_reg + l_reg;
    assign p_idx = (periodic_reg && p_raw >= n_reg) ? p_raw - n_reg : p_raw;

    always_ff @(posedge aclk) begin
        if (accept && in_cmd == CMD_CTRL && IW'(in_slot) < IW'(MAX_POINTS)
                && {1'b0, in_csel} <= 3'(MAX_COORDS)) begin
            ctrl_mem[CAW'(in_csel) * CAW'(MAX_POINTS) + CAW'(in_slot)] <= in_value;
        end
        crd_reg  <= ctrl_mem[CAW'(c_reg) * CAW'(MAX_POINTS) + p_idx[CAW-1:0]];
        coob_reg <= p_idx >= IW'(MAX_POINTS);
    end

    assign ctrl_val = coob_reg ? 32'sd0 : crd_reg;

    assign bidx     = (state_reg == S_DIV && term_b_reg) ? l_reg : l_reg + IW'(1);
    assign basis_rd = basis_reg[bidx[BW-1:0]];
    assign s1_now   = 33'(knot_val) - 33'(lo_reg);
    assign qt       = qtrunc(prod_reg);
    assign acc_new  = acc_reg + 64'(qt);

    // divider launch
    always_comb begin
        div_start = 1'b0;
        div_num   = 33'(t_reg) - 33'(lo_reg);
        div_den   = s1_reg;
        case (state_reg)
            S_CDB4: begin
                if (s2_reg > 0) begin
                    div_start = 1'b1;
                    div_num   = 33'(hi_reg) - 33'(t_reg);
                    div_den   = s2_reg;
                end else if (s1_now > 0) begin
                    div_start = 1'b1;
                    div_den   = s1_now;
                end
            end
            S_MULR: begin
                div_start = !term_b_reg && (s1_reg > 0);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    bsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .ratio   (div_ratio)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_tvalid_reg     <= 1'b0;
            cfg_order_reg    <= 4'd4;
            cfg_points_reg   <= 9'd4;
            cfg_periodic_reg <= 1'b0;
            cfg_rational_reg <= 1'b0;
            cfg_coords_reg   <= 2'd3;
            for (int j = 0; j <= MAX_ORDER; j++) begin
                basis_reg[j] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ORDER:    cfg_order_reg    <= cfg_data[3:0];
                    CFG_POINTS:   cfg_points_reg   <= cfg_data;
                    CFG_PERIODIC: cfg_periodic_reg <= cfg_data[0];
                    CFG_RATIONAL: cfg_rational_reg <= cfg_data[0];
                    CFG_COORDS:   cfg_coords_reg   <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == S_MUL || state_reg == S_SUMM) begin
                prod_reg <= mul_a_reg * mul_b_reg;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept && in_cmd == CMD_EVAL) begin
                        t_reg         <= in_t;
                        n_reg         <= n_eff;
                        k_reg         <= k_eff;
                        len_reg       <= len_eff;
                        kvlen_reg     <= k_eff + len_eff;
                        nc_reg        <= nc_eff;
                        periodic_reg  <= cfg_periodic_reg;
                        rational_reg  <= cfg_rational_reg;
                        first_out_reg <= '0;
                        err_reg       <= 1'b0;
                        for (int j = 0; j < 4; j++) begin
                            res_reg[j] <= '0;
                        end
                        state_reg <= S_DOM0;
                    end
                end
                S_DOM0: state_reg <= S_DOM1;
                S_DOM1: begin
                    lo_reg    <= knot_val;
                    state_reg <= S_DOM2;
                end
                S_DOM2: begin
                    if (t_reg < lo_reg || t_reg > knot_val) begin
                        err_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg   <= k_reg - IW'(1);
                        state_reg <= S_SRCH0;
                    end
                end
                S_SRCH0: begin
                    state_reg <= (idx_reg + IW'(1) < kvlen_reg) ? S_SRCH1 : S_BSET;
                end
                S_SRCH1: begin
                    if (knot_val <= t_reg) begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= S_SRCH0;
                    end else begin
                        state_reg <= S_BSET;
                    end
                end
                S_BSET: begin
                    for (int j = 0; j <= MAX_ORDER; j++) begin
                        if (idx_reg >= kvlen_reg - IW'(1)) begin
                            basis_reg[j] <= (IW'(j) == k_reg) ? Q_ONE : '0;
                        end else begin
                            basis_reg[j] <= (j == 1) ? Q_ONE : '0;
                        end
                    end
                    if (idx_reg >= kvlen_reg - IW'(1)) begin
                        first_reg <= len_reg - k_reg;
                        state_reg <= S_SUM0;
                    end else begin
                        i_reg <= IW'(2);
                        l_reg <= IW'(1);
                        if (idx_reg - k_reg + IW'(1) >= n_reg) begin
                            first_reg <= idx_reg - k_reg + IW'(1) - n_reg;
                        end else begin
                            first_reg <= idx_reg - k_reg + IW'(1);
                        end
                        state_reg <= S_CDB0;
                    end
                end
                S_CDB0: state_reg <= S_CDB1;
                S_CDB1: begin
                    hi_reg    <= knot_val;
                    state_reg <= S_CDB2;
                end
                S_CDB2: begin
                    s2_reg    <= 33'(hi_reg) - 33'(knot_val);
                    state_reg <= S_CDB3;
                end
                S_CDB3: begin
                    lo_reg    <= knot_val;
                    state_reg <= S_CDB4;
                end
                S_CDB4: begin
                    s1_reg <= s1_now;
                    if (s2_reg > 0) begin
                        term_b_reg <= 1'b0;
                        state_reg  <= S_DIV;
                    end else begin
                        a_reg      <= '0;
                        term_b_reg <= 1'b1;
                        if (s1_now > 0) begin
                            state_reg <= S_DIV;
                        end else begin
                            b_reg     <= '0;
                            state_reg <= S_WB;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        mul_a_reg <= basis_rd;
                        mul_b_reg <= div_ratio;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_MULR;
                S_MULR: begin
                    if (!term_b_reg) begin
                        a_reg      <= qt;
                        term_b_reg <= 1'b1;
                        if (s1_reg > 0) begin
                            state_reg <= S_DIV;
                        end else begin
                            b_reg     <= '0;
                            state_reg <= S_WB;
                        end
                    end else begin
                        b_reg     <= qt;
                        state_reg <= S_WB;
                    end
                end
                S_WB: begin
                    basis_reg[bidx[BW-1:0]] <= sat32(64'(a_reg) + 64'(b_reg));
                    if (l_reg == '0) begin
                        if (i_reg == k_reg) begin
                            state_reg <= S_SUM0;
                        end else begin
                            l_reg     <= i_reg;
                            i_reg     <= i_reg + IW'(1);
                            state_reg <= S_CDB0;
                        end
                    end else begin
                        l_reg     <= l_reg - IW'(1);
                        state_reg <= S_CDB0;
                    end
                end
                S_SUM0: begin
                    c_reg     <= rational_reg ? 2'd0 : 2'd1;
                    l_reg     <= '0;
                    acc_reg   <= '0;
                    state_reg <= S_SUM1;
                end
                S_SUM1: begin
                    mul_b_reg <= basis_rd;
                    state_reg <= S_SUM2;
                end
                S_SUM2: begin
                    mul_a_reg <= ctrl_val;
                    state_reg <= S_SUMM;
                end
                S_SUMM: state_reg <= S_SUM3;
                S_SUM3: begin
                    if (l_reg == k_reg - IW'(1)) begin
                        res_reg[c_reg] <= sat32(acc_new);
                        if (c_reg == nc_reg) begin
                            first_out_reg <= first_reg[7:0];
                            state_reg     <= S_OUT;
                        end else begin
                            c_reg     <= c_reg + 2'd1;
                            l_reg     <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_SUM1;
                        end
                    end else begin
                        acc_reg   <= acc_new;
                        l_reg     <= l_reg + IW'(1);
                        state_reg <= S_SUM1;
                    end
                end
                S_OUT: begin
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {first_out_reg, res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
    assign m_tuser  = err_reg;

endmodule

[design/bsp_div.sv]
module bsp_div
    import bsp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [32:0] num,
    input  logic        [32:0] den,
    output logic               done,
    output logic signed [31:0] ratio
);

    localparam int QW = 33 + Q_FRAC;

    logic          busy_reg;
    logic          done_reg;
    logic [5:0]    cnt_reg;
    logic [QW-1:0] dvd_reg;
    logic [33:0]   rem_reg;
    logic [32:0]   den_reg;
    logic          neg_reg;

    logic [32:0]   mag;
    logic [33:0]   rem_sh;
    logic          qbit;
    logic [33:0]   rem_next;

    assign mag    = num[32] ? 33'(-num) : 33'(num);
    assign rem_sh = {rem_reg[32:0], dvd_reg[QW-1]};
    assign qbit   = rem_sh >= {1'b0, den_reg};
    assign rem_next = qbit ? rem_sh - {1'b0, den_reg} : rem_sh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= {mag, {Q_FRAC{1'b0}}};
                rem_reg  <= '0;
                den_reg  <= den;
                neg_reg  <= num[32];
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[QW-2:0], qbit};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // signed, saturated quotient
    always_comb begin
        if (neg_reg) begin
            if (dvd_reg > QW'(33'h0_8000_0000)) begin
                ratio = 32'sh8000_0000;
            end else begin
                ratio = 32'(-dvd_reg);
            end
        end else begin
            if (dvd_reg > QW'(33'h0_7fff_ffff)) begin
                ratio = 32'sh7fff_ffff;
            end else begin
                ratio = dvd_reg[31:0];
            end
        end
    end

    assign done = done_reg;

endmodule

[design/bsp_checker.sv]
module bsp_checker
    import bsp_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic         m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an out-of-domain result carries no point
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("domain error with nonzero point");

    // an evaluate item keeps the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == CMD_EVAL |=> !s_tready)
        else $error("ready right after evaluate item");

    // no input taken while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind bspline_curve_point_eval bsp_checker u_bsp_checker (.*);

[bench/bspline_curve_point_eval_tb.sv]
`timescale 1ns / 100ps

module bspline_curve_point_eval_tb;
    import bsp_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int KNOT_DEPTH = MAX_ORDER_DEF * 2 + MAX_POINTS_DEF;
    localparam int CTRL_DEPTH = (MAX_COORDS_DEF + 1) * MAX_POINTS_DEF;
    localparam longint UNIT = 65536;

    typedef struct packed {
        logic        err;
        logic [7:0]  first;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
        logic [31:0] w;
    } point_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         m_tuser;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [8:0]   cfg_data = '0;

    bspline_curve_point_eval dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // shadow state
    int          knot_mem [KNOT_DEPTH];
    int          coord_mem [CTRL_DEPTH];
    logic [3:0]  order_reg = 4'd4;
    logic [8:0]  points_reg = 9'd4;
    logic        periodic_reg = 1'b0;
    logic        rational_reg = 1'b0;
    logic [1:0]  coords_reg = 2'd3;

    point_t pending_points [$];
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int evals_sent = 0;
    int range_errors = 0;
    int results_seen = 0;
    int errors = 0;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint knot_val(input longint i);
        if (i < 0 || i >= KNOT_DEPTH) return 0;
        return knot_mem[i];
    endfunction

    function automatic void curve_sizes(output longint n, output longint k,
                                        output longint len, output int nc);
        n = points_reg;
        if (n < 2) n = 2;
        if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
        k = order_reg;
        if (k < 2) k = 2;
        if (k > MAX_ORDER_DEF) k = MAX_ORDER_DEF;
        if (k > n) k = n;
        nc = coords_reg;
        if (nc < 1) nc = 1;
        if (nc > MAX_COORDS_DEF) nc = MAX_COORDS_DEF;
        len = periodic_reg ? n + k - 1 : n;
    endfunction

    function automatic point_t curve_point(input int t_in);
        point_t r;
        longint n, k, len, kv, t, idx, first, hi, lo, s1, s2, a, b, acc, p, v;
        longint bw [0:MAX_ORDER_DEF];
        int nc, i, l, c;
        r = '0;
        curve_sizes(n, k, len, nc);
        kv = k + len;
        t = t_in;
        if (t < knot_val(k - 1) || t > knot_val(len)) begin
            r.err = 1'b1;
            return r;
        end
        idx = k - 1;
        while (idx + 1 < kv && knot_val(idx + 1) <= t) idx++;
        for (i = 0; i <= MAX_ORDER_DEF; i++) bw[i] = 0;
        if (idx >= kv - 1) begin
            bw[k] = UNIT;
            first = len - k;
        end else begin
            bw[1] = UNIT;
            for (i = 2; i <= k; i++) begin
                for (l = i - 1; l >= 0; l--) begin
                    hi = knot_val(idx + l + 1);
                    s2 = hi - knot_val(idx + l - i + 2);
                    lo = knot_val(idx + l - i + 1);
                    s1 = knot_val(idx + l) - lo;
                    a = 0;
                    b = 0;
                    if (s2 > 0) a = (bw[l + 1] * clip32(((hi - t) * UNIT) / s2)) / UNIT;
                    if (s1 > 0) b = (bw[l] * clip32(((t - lo) * UNIT) / s1)) / UNIT;
                    bw[l + 1] = clip32(a + b);
                end
            end
            first = idx - k + 1;
            if (first >= n) first -= n;
        end
        for (c = rational_reg ? 0 : 1; c <= nc; c++) begin
            acc = 0;
            for (l = 0; l < k; l++) begin
                p = first + l;
                if (periodic_reg) p = p % n;
                v = (p >= 0 && p < MAX_POINTS_DEF) ? coord_mem[c * MAX_POINTS_DEF + p] : 0;
                acc += (v * bw[l + 1]) / UNIT;
            end
            case (c)
                0: r.w = clip32(acc);
                1: r.x = clip32(acc);
                2: r.y = clip32(acc);
                default: r.z = clip32(acc);
            endcase
        end
        r.first = first[7:0];
        return r;
    endfunction

    task automatic send_item(input logic [1:0] c, input int unsigned sl,
                             input int unsigned cs, input int wv, input int t);
        point_t e;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= {5'b0, t[31:0], wv[31:0], cs[1:0], sl[8:0]};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        case (c)
            CMD_KNOT: if (sl < KNOT_DEPTH) knot_mem[sl] = wv;
            CMD_CTRL: if (sl < MAX_POINTS_DEF) coord_mem[cs * MAX_POINTS_DEF + sl] = wv;
            CMD_EVAL: begin
                e = curve_point(t);
                evals_sent++;
                if (e.err) range_errors++;
                pending_points.push_back(e);
            end
            default: ;
        endcase
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_config(input int ord, input int pts, input int per,
                              input int rat, input int crd);
        int vals [5];
        logic [2:0] regs [5];
        drain_results();
        vals = '{ord, pts, per, rat, crd};
        regs = '{CFG_ORDER, CFG_POINTS, CFG_PERIODIC, CFG_RATIONAL, CFG_COORDS};
        for (int i = 0; i < 5; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= 9'(vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        order_reg = 4'(ord);
        points_reg = 9'(pts);
        periodic_reg = per[0];
        rational_reg = rat[0];
        coords_reg = 2'(crd);
    endtask

    // writes every knot and coordinate the current setting can reach
    task automatic load_curve(input bit clamped);
        longint n, k, len;
        int nc, top, val;
        curve_sizes(n, k, len, nc);
        top = int'(k + len + k - 2);
        if (top > KNOT_DEPTH - 1) top = KNOT_DEPTH - 1;
        val = -int'($urandom_range(0, 4)) * int'(UNIT);
        for (int i = 0; i <= top; i++) begin
            if (i > 0 && !(clamped && (i < k || i > len)))
                val += ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, 3 * UNIT));
            send_item(CMD_KNOT, i, $urandom_range(0, 3), val, $urandom);
        end
        top = int'(len + k - 2);
        if (top > MAX_POINTS_DEF - 1) top = MAX_POINTS_DEF - 1;
        for (int c = rational_reg ? 0 : 1; c <= nc; c++) begin
            for (int p = 0; p <= top; p++) begin
                val = ($urandom_range(0, 7) == 0) ? int'($urandom)
                    : int'($urandom_range(0, 200 * UNIT)) - int'(100 * UNIT);
                send_item(CMD_CTRL, p, c, val, $urandom);
            end
        end
    endtask

    task automatic eval_random();
        longint n, k, len, lo, hi;
        int nc, t, pick;
        curve_sizes(n, k, len, nc);
        lo = knot_val(k - 1);
        hi = knot_val(len);
        pick = $urandom_range(0, 99);
        if (hi < lo || pick < 15) t = $urandom;
        else if (pick < 60) t = int'(lo + $urandom_range(0, hi - lo));
        else if (pick < 75) t = int'(knot_val($urandom_range(k - 1, len)));
        else if (pick < 85) t = ($urandom_range(0, 1)) ? int'(lo) : int'(hi);
        else t = ($urandom_range(0, 1)) ? int'(lo - 1) : int'(hi + 1);
        send_item(CMD_EVAL, $urandom_range(0, 511), $urandom_range(0, 3), $urandom, t);
    endtask

    task automatic mixed_items(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) eval_random();
            else if (pick < 80)
                send_item(CMD_CTRL, $urandom_range(0, 511), $urandom_range(0, 3),
                          $urandom, $urandom);
            else if (pick < 90)
                send_item(CMD_KNOT, $urandom_range(KNOT_DEPTH, 511), $urandom_range(0, 3),
                          $urandom, $urandom);
            else if (pick < 95)
                send_item(CMD_KNOT, $urandom_range(0, KNOT_DEPTH - 1), 0,
                          $urandom, $urandom);
            else
                send_item(CMD_SPARE, $urandom_range(0, 511), $urandom_range(0, 3),
                          $urandom, $urandom);
        end
    endtask

    task automatic test_default_curve();
        longint n, k, len;
        int nc;
        load_curve(1'b1);
        curve_sizes(n, k, len, nc);
        send_item(CMD_EVAL, 0, 0, 0, int'(knot_val(k - 1)));
        send_item(CMD_EVAL, 511, 3, -1, int'(knot_val(len)));
        send_item(CMD_EVAL, 0, 0, 0, int'(knot_val(k - 1) - 1));
        send_item(CMD_EVAL, 0, 0, 0, int'(knot_val(len) + 1));
        send_item(CMD_EVAL, 0, 0, 0, 32'sh8000_0000);
        send_item(CMD_EVAL, 0, 0, 0, 32'sh7fff_ffff);
        for (longint i = k; i < len; i++) send_item(CMD_EVAL, 0, 0, 0, int'(knot_val(i)));
        send_item(CMD_EVAL, 0, 0, 0, int'((knot_val(k - 1) + knot_val(len)) / 2));
        send_item(CMD_SPARE, 511, 3, -1, -1);
        send_item(CMD_KNOT, KNOT_DEPTH, 0, 32'sh7fff_ffff, 0);
        send_item(CMD_KNOT, 511, 0, 32'sh8000_0000, 0);
        send_item(CMD_CTRL, MAX_POINTS_DEF, 1, 32'sh7fff_ffff, 0);
        send_item(CMD_CTRL, 511, 3, 32'sh8000_0000, 0);
        send_item(CMD_EVAL, 0, 0, 0, int'((knot_val(k - 1) + knot_val(len)) / 2));
    endtask

    task automatic test_config_extremes();
        int settings [6][5];
        settings = '{'{0, 0, 0, 0, 0}, '{15, 9, 0, 1, 3}, '{1, 1, 1, 1, 1},
                     '{8, 2, 1, 0, 2}, '{2, 3, 0, 1, 0}, '{3, 5, 1, 1, 3}};
        foreach (settings[i]) begin
            set_config(settings[i][0], settings[i][1], settings[i][2],
                       settings[i][3], settings[i][4]);
            load_curve($urandom_range(0, 1));
            repeat (5) eval_random();
        end
    endtask

    task automatic test_largest_curve();
        set_config(15, 511, 1, 0, 1);
        load_curve(1'b1);
        repeat (6) eval_random();
    endtask

    task automatic test_random_curves();
        int goal;
        for (int mode = 0; mode < 3; mode++) begin
            idle_pct = (mode == 0) ? 31 : (mode == 1) ? 46 : 0;
            stall_pct = (mode == 0) ? 46 : (mode == 1) ? 31 : 0;
            goal = items_sent + 170;
            while (items_sent < goal) begin
                set_config(($urandom_range(0, 9) == 0) ? $urandom_range(6, 8)
                                                       : $urandom_range(0, 5),
                           $urandom_range(0, 12), $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 3));
                load_curve($urandom_range(0, 1));
                mixed_items($urandom_range(20, 40));
            end
        end
    endtask

    always @(posedge aclk) begin
        point_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[135:128], m_tdata[127:96], m_tdata[95:64],
                   m_tdata[63:32], m_tdata[31:0]};
            results_seen++;
            if (pending_points.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %h", got);
            end else begin
                want = pending_points.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: w %h/%h x %h/%h y %h/%h z %h/%h ",
                                  "first %0d/%0d err %b/%b (expected/actual)"},
                                 want.w, got.w, want.x, got.x, want.y, got.y,
                                 want.z, got.z, want.first, got.first,
                                 want.err, got.err);
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_curve();
        test_config_extremes();
        test_largest_curve();
        test_random_curves();
        drain_results();
        repeat (4000) @(posedge aclk);
        $display("%0d items sent, %0d curve evaluations (%0d outside the domain)",
                 items_sent, evals_sent, range_errors);
        $display("%0d result items checked, %0d mismatches", results_seen, errors);
        if (errors == 0 && pending_points.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[bspline_curve_point_eval.f]
design/bsp_pkg.sv
design/bsp_div.sv
design/bspline_curve_point_eval.sv
design/bsp_checker.sv
bench/bspline_curve_point_eval_tb.sv
